// ----- rtl/lcdseq_pkg.sv -----
// Shared types, codes and tables for the character LCD nibble write sequencer.
package lcdseq_pkg;

  // Request codes carried on the input channel's tuser.
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_CMD    = 3'd1;
  localparam logic [2:0] OP_DATA   = 3'd2;
  localparam logic [2:0] OP_CURSOR = 3'd3;
  localparam logic [2:0] OP_INIT   = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_PULSE      = 3'd0;
  localparam logic [2:0] REG_GAP        = 3'd1;
  localparam logic [2:0] REG_SETTLE     = 3'd2;
  localparam logic [2:0] REG_POWERUP    = 3'd3;
  localparam logic [2:0] REG_INIT_NIB   = 3'd4;
  localparam logic [2:0] REG_INIT_CMD   = 3'd5;

  // Timing registers as seen by the sequencer.
  typedef struct packed {
    logic [3:0] pulse_ticks;
    logic [3:0] gap_ticks;
    logic [3:0] settle_ticks;
    logic [9:0] powerup_ticks;
    logic [5:0] init_nibble_ticks;
    logic [3:0] init_cmd_ticks;
  } cfg_t;

  // Bus levels and status reported after each word.
  typedef struct packed {
    logic [3:0] data_nibble;
    logic       reg_select;
    logic       enable;
    logic       busy_res;
    logic       rejected;
  } res_t;

  // Command bytes of the init sequence, numbered from one.
  function automatic logic [7:0] init_cmd(input logic [2:0] step);
    logic [7:0] cmd;
    case (step)
      3'd1:    cmd = 8'h2C;
      3'd2:    cmd = 8'h2C;
      3'd3:    cmd = 8'h0F;
      3'd4:    cmd = 8'h01;
      3'd5:    cmd = 8'h06;
      default: cmd = 8'h00;
    endcase
    return cmd;
  endfunction

endpackage

// ----- rtl/lcdseq_cfg.sv -----
// APB-style register file holding the sequencer's timing settings.
module lcdseq_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  output lcdseq_pkg::cfg_t   cfg
);
  import lcdseq_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg        = cfg_r;

  // Register writes; the reset values match the display's datasheet defaults.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_ticks       <= 4'd1;
      cfg_r.gap_ticks         <= 4'd1;
      cfg_r.settle_ticks      <= 4'd2;
      cfg_r.powerup_ticks     <= 10'd100;
      cfg_r.init_nibble_ticks <= 6'd5;
      cfg_r.init_cmd_ticks    <= 4'd1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PULSE:    cfg_r.pulse_ticks       <= cfg_pwdata[3:0];
        REG_GAP:      cfg_r.gap_ticks         <= cfg_pwdata[3:0];
        REG_SETTLE:   cfg_r.settle_ticks      <= cfg_pwdata[3:0];
        REG_POWERUP:  cfg_r.powerup_ticks     <= cfg_pwdata[9:0];
        REG_INIT_NIB: cfg_r.init_nibble_ticks <= cfg_pwdata[5:0];
        REG_INIT_CMD: cfg_r.init_cmd_ticks    <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (reg_idx)
      REG_PULSE:    cfg_prdata = {28'd0, cfg_r.pulse_ticks};
      REG_GAP:      cfg_prdata = {28'd0, cfg_r.gap_ticks};
      REG_SETTLE:   cfg_prdata = {28'd0, cfg_r.settle_ticks};
      REG_POWERUP:  cfg_prdata = {22'd0, cfg_r.powerup_ticks};
      REG_INIT_NIB: cfg_prdata = {26'd0, cfg_r.init_nibble_ticks};
      REG_INIT_CMD: cfg_prdata = {28'd0, cfg_r.init_cmd_ticks};
      default:      cfg_prdata = 32'd0;
    endcase
  end

endmodule

// ----- rtl/lcdseq_fsm.sv -----
// Bus sequencer: phase, delay counter and nibble state, advanced once per accepted word.
module lcdseq_fsm #(
  parameter int DELAY_COUNTER_BITS = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [2:0]       op,
  input  logic [7:0]       value,
  input  logic [2:0]       row,
  input  logic [3:0]       col,
  input  lcdseq_pkg::cfg_t cfg,
  output lcdseq_pkg::res_t res
);
  import lcdseq_pkg::*;

  localparam int CW = (DELAY_COUNTER_BITS > 10) ? DELAY_COUNTER_BITS : 10;
  localparam logic [CW-1:0] WAIT_MAX = CW'((1 << DELAY_COUNTER_BITS) - 1);

  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_HI_PULSE   = 4'd1;
  localparam logic [3:0] PH_HI_GAP     = 4'd2;
  localparam logic [3:0] PH_LO_PULSE   = 4'd3;
  localparam logic [3:0] PH_SETTLE     = 4'd4;
  localparam logic [3:0] PH_PWR_WAIT   = 4'd5;
  localparam logic [3:0] PH_WAKE_PULSE = 4'd6;
  localparam logic [3:0] PH_WAKE_WAIT  = 4'd7;
  localparam logic [3:0] PH_FOUR_PULSE = 4'd8;
  localparam logic [3:0] PH_FOUR_WAIT  = 4'd9;
  localparam logic [3:0] PH_CMD_WAIT   = 4'd10;

  logic [3:0]                    phase_r, phase_nxt;
  logic [DELAY_COUNTER_BITS-1:0] wait_r, wait_nxt;
  logic [7:0]                    byte_r, byte_nxt;
  logic                          rs_r, rs_nxt;
  logic [2:0]                    step_r, step_nxt;
  logic [3:0]                    nib_r, nib_nxt;
  logic                          en_r, en_nxt;
  logic                          busy;
  logic                          rej;
  logic [2:0]                    step_inc;
  logic [7:0]                    row_base;
  logic [3:0]                    col_eff;
  logic [7:0]                    cursor_addr;

  // A zero setting counts as one tick; long settings clip at the counter's top.
  function automatic logic [DELAY_COUNTER_BITS-1:0] load_wait(input logic [9:0] n);
    logic [CW-1:0] ext;
    ext = CW'(n);
    if (ext == '0) ext = CW'(1);
    if (ext > WAIT_MAX) ext = WAIT_MAX;
    return ext[DELAY_COUNTER_BITS-1:0];
  endfunction

  assign busy     = (phase_r != PH_IDLE);
  assign step_inc = step_r + 3'd1;

  // Cursor address: row base plus column, with the set-address bit on top.
  always_comb begin
    col_eff = col;
    case (row)
      3'd1:    row_base = 8'd0;
      3'd2:    row_base = 8'd64;
      3'd3:    row_base = 8'd16;
      3'd4:    row_base = 8'd80;
      default: begin
        row_base = 8'd0;
        col_eff  = 4'd0;
      end
    endcase
    cursor_addr = row_base + {4'd0, col_eff} + 8'd128;
  end

  // Next state for one word: a tick advances the timer or the phase, a request starts work.
  always_comb begin
    phase_nxt = phase_r;
    wait_nxt  = wait_r;
    byte_nxt  = byte_r;
    rs_nxt    = rs_r;
    step_nxt  = step_r;
    nib_nxt   = nib_r;
    en_nxt    = en_r;
    rej       = 1'b0;

    if (op == OP_TICK) begin
      if (busy && wait_r > DELAY_COUNTER_BITS'(1)) begin
        wait_nxt = wait_r - DELAY_COUNTER_BITS'(1);
      end else if (busy) begin
        unique case (phase_r)
          PH_HI_PULSE: begin
            en_nxt    = 1'b0;
            phase_nxt = PH_HI_GAP;
            wait_nxt  = load_wait({6'd0, cfg.gap_ticks});
          end
          PH_HI_GAP: begin
            nib_nxt   = byte_r[3:0];
            en_nxt    = 1'b1;
            phase_nxt = PH_LO_PULSE;
            wait_nxt  = load_wait({6'd0, cfg.pulse_ticks});
          end
          PH_LO_PULSE: begin
            en_nxt    = 1'b0;
            nib_nxt   = 4'd0;
            rs_nxt    = 1'b0;
            phase_nxt = PH_SETTLE;
            wait_nxt  = load_wait({6'd0, cfg.settle_ticks});
          end
          PH_SETTLE: begin
            if (step_r != 3'd0) begin
              phase_nxt = PH_CMD_WAIT;
              wait_nxt  = load_wait({6'd0, cfg.init_cmd_ticks});
            end else begin
              phase_nxt = PH_IDLE;
              wait_nxt  = '0;
            end
          end
          PH_PWR_WAIT: begin
            rs_nxt    = 1'b0;
            nib_nxt   = 4'd3;
            en_nxt    = 1'b1;
            phase_nxt = PH_WAKE_PULSE;
            wait_nxt  = load_wait(10'd1);
          end
          PH_WAKE_PULSE: begin
            en_nxt    = 1'b0;
            phase_nxt = PH_WAKE_WAIT;
            wait_nxt  = load_wait({4'd0, cfg.init_nibble_ticks});
          end
          PH_WAKE_WAIT: begin
            step_nxt = step_inc;
            en_nxt   = 1'b1;
            wait_nxt = load_wait(10'd1);
            if (step_inc < 3'd3) begin
              nib_nxt   = 4'd3;
              phase_nxt = PH_WAKE_PULSE;
            end else begin
              nib_nxt   = 4'd2;
              phase_nxt = PH_FOUR_PULSE;
            end
          end
          PH_FOUR_PULSE: begin
            en_nxt    = 1'b0;
            phase_nxt = PH_FOUR_WAIT;
            wait_nxt  = load_wait({6'd0, cfg.init_cmd_ticks});
          end
          PH_FOUR_WAIT: begin
            step_nxt  = 3'd1;
            byte_nxt  = init_cmd(3'd1);
            rs_nxt    = 1'b0;
            nib_nxt   = byte_nxt[7:4];
            en_nxt    = 1'b1;
            phase_nxt = PH_HI_PULSE;
            wait_nxt  = load_wait({6'd0, cfg.pulse_ticks});
          end
          PH_CMD_WAIT: begin
            if (step_inc >= 3'd1 && step_inc <= 3'd5) begin
              step_nxt  = step_inc;
              byte_nxt  = init_cmd(step_inc);
              rs_nxt    = 1'b0;
              nib_nxt   = byte_nxt[7:4];
              en_nxt    = 1'b1;
              phase_nxt = PH_HI_PULSE;
              wait_nxt  = load_wait({6'd0, cfg.pulse_ticks});
            end else begin
              step_nxt  = 3'd0;
              phase_nxt = PH_IDLE;
              wait_nxt  = '0;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
            wait_nxt  = '0;
          end
        endcase
      end
    end else if (op == OP_CMD || op == OP_DATA || op == OP_CURSOR || op == OP_INIT) begin
      if (busy) begin
        rej = 1'b1;
      end else if (op == OP_INIT) begin
        rs_nxt    = 1'b0;
        nib_nxt   = 4'd0;
        en_nxt    = 1'b0;
        step_nxt  = 3'd0;
        phase_nxt = PH_PWR_WAIT;
        wait_nxt  = load_wait(cfg.powerup_ticks);
      end else begin
        byte_nxt  = (op == OP_CURSOR) ? cursor_addr : value;
        rs_nxt    = (op == OP_DATA);
        nib_nxt   = byte_nxt[7:4];
        en_nxt    = 1'b1;
        phase_nxt = PH_HI_PULSE;
        wait_nxt  = load_wait({6'd0, cfg.pulse_ticks});
      end
    end
  end

  // Sequencer state, updated only when a word is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      wait_r  <= '0;
      byte_r  <= 8'd0;
      rs_r    <= 1'b0;
      step_r  <= 3'd0;
      nib_r   <= 4'd0;
      en_r    <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      wait_r  <= wait_nxt;
      byte_r  <= byte_nxt;
      rs_r    <= rs_nxt;
      step_r  <= step_nxt;
      nib_r   <= nib_nxt;
      en_r    <= en_nxt;
    end
  end

  // Bus levels after this word.
  assign res.data_nibble = nib_nxt;
  assign res.reg_select  = rs_nxt;
  assign res.enable      = en_nxt;
  assign res.busy_res    = (phase_nxt != PH_IDLE);
  assign res.rejected    = rej;

endmodule

// ----- rtl/char_lcd_nibble_write_sequencer.sv -----
// Top level of the character LCD 4-bit write sequencer with its result register.
//
// Usage: each input word carries a request code on in_tuser (tick, command
// byte, data byte, cursor move or init) and its operands on in_tdata. Ticks
// time every enable pulse and gap; requests start a byte or the power-up
// init sequence. Every accepted word yields exactly one output word with the
// D7..D4, RS, RW and EN levels after that word, a busy flag and a flag that
// marks a request dropped because a byte or init was still running.
// Latency: the result word is valid the cycle after its input word is taken.
// Throughput: one word per cycle; the next word is taken while a result
// waits, as long as the receiver takes the waiting result in that same cycle.
// Stall: while out_tready is low and a result is held, in_tready is low.
// Reset (rst_n low, synchronous): sequencer idle, all bus levels low, result
// register empty, timing registers at defaults. The user must write timing
// registers over the cfg_ APB port only while idle; the block does not check.
module char_lcd_nibble_write_sequencer #(
  parameter int DELAY_COUNTER_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input words.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // value[7:0], row[10:8], col[14:11], zero[15]
  input  logic [2:0]  in_tuser,  // op[2:0]
  // Result words.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata, // data_nibble[3:0], reg_select[4], read_write[5],
                                 // enable[6], busy_res[7], rejected[8], zero[15:9]
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lcdseq_pkg::*;

  cfg_t  cfg;
  res_t  res;
  res_t  res_r;
  logic  out_tvalid_r;
  logic  accept;

  assign in_tready = !out_tvalid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  lcdseq_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  lcdseq_fsm #(
    .DELAY_COUNTER_BITS (DELAY_COUNTER_BITS)
  ) u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .op     (in_tuser),
    .value  (in_tdata[7:0]),
    .row    (in_tdata[10:8]),
    .col    (in_tdata[14:11]),
    .cfg    (cfg),
    .res    (res)
  );

  // Result register: filled on accept, emptied when the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (accept) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, res_r.rejected, res_r.busy_res, res_r.enable, 1'b0,
                       res_r.reg_select, res_r.data_nibble};

  // A dropped request only happens while a sequence runs, and that sequence goes on.
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && res_r.rejected |-> res_r.busy_res)
    else $error("rejected word reported while idle");

  // Enable is only ever strobed as part of a running byte or init sequence.
  a_enable_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && res_r.enable |-> res_r.busy_res)
    else $error("enable high while idle");

  // An idle bus rests with data, RS and enable low.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && !res_r.busy_res |->
      res_r.data_nibble == 4'd0 && !res_r.reg_select && !res_r.enable)
    else $error("bus not quiet while idle");

endmodule
